// ===== rtl/tdps_pkg.sv =====
// Shared constants, types and the Hann window table for the two-tap pitch shifter.
package tdps_pkg;

	localparam int LINE_LEN = 2048;
	localparam int LINE_AW  = $clog2(LINE_LEN);
	localparam int SAMPLE_W = 24;
	localparam int WIN_W    = 16;
	localparam int FRAC_W   = 16;
	localparam int DELAY_W  = LINE_AW + FRAC_W;
	localparam int INC_W    = 19;

	localparam logic [LINE_AW-1:0] LINE_HALF = LINE_AW'(LINE_LEN / 2);
	localparam logic [LINE_AW-1:0] LINE_LAST = LINE_AW'(LINE_LEN - 1);

	// configuration port
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_PHASE_INC = 1'd0;

	// sequencer steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] ST_RD_A0 = 4'd1;
	localparam logic [STEP_W-1:0] ST_RD_B0 = 4'd2;
	localparam logic [STEP_W-1:0] ST_RD_A1 = 4'd3;
	localparam logic [STEP_W-1:0] ST_RD_B1 = 4'd4;
	localparam logic [STEP_W-1:0] ST_MUL1  = 4'd5;
	localparam logic [STEP_W-1:0] ST_FIN1  = 4'd6;
	localparam logic [STEP_W-1:0] ST_TAP1  = 4'd7;
	localparam logic [STEP_W-1:0] ST_DONE  = 4'd8;

	// datapath strobes from sequencer to lanes
	typedef struct packed {
		logic load_a;
		logic lerp_mul;
		logic lerp_fin;
		logic tap_mul;
		logic acc_init;
	} tdps_ctl_t;

	typedef logic [LINE_LEN-1:0][WIN_W-1:0] hann_rom_t;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	// sin^2(pi*i/N) in Q15 from a Q30 Taylor series
	function automatic logic [WIN_W-1:0] hann_entry(int unsigned i);
		longint unsigned k;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned h;
		k  = (i <= LINE_LEN / 2) ? 64'(i) : 64'(LINE_LEN - i);
		x  = (k * PI_Q30) / LINE_LEN;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		h  = ((s * s) >> 30) + 64'd16384;
		h  = h >> 15;
		if (h > 64'd32768) begin
			h = 64'd32768;
		end
		return h[WIN_W-1:0];
	endfunction

	function automatic hann_rom_t hann_rom_init();
		hann_rom_t rom;
		for (int i = 0; i < LINE_LEN; i++) begin
			rom[i] = hann_entry(i);
		end
		return rom;
	endfunction

	localparam hann_rom_t HANN_ROM = hann_rom_init();

endpackage

// ===== rtl/tdps_in_if.sv =====
// Input stream interface: one stereo sample pair per transfer.
interface tdps_in_if
	import tdps_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_in;
	logic signed [SAMPLE_W-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ===== rtl/tdps_out_if.sv =====
// Output stream interface: one shifted stereo sample pair per transfer.
interface tdps_out_if
	import tdps_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/two_tap_delay_pitch_shifter.sv =====
// Top level of the two-tap delay-line pitch shifter with stereo crossfade.
//
//   port        dir  kind          carries
//   sample_in   in   valid/ready   left_in, right_in (24b signed pair)
//   sample_out  out  valid/ready   left_out, right_out (24b signed, saturated)
//   psel..      in   APB-style     phase_increment at byte 0 (19b signed)
//
// The new pair is written into the sample line on the accepting edge; the four tap
// reads then go one per cycle through the single read port of the sample line, and
// three more stages (MUL1, FIN1, TAP1) follow the last one.
// A finished pair waits in the output register; a new input transfer is taken
// while it waits, and the sequencer holds its last step only if the previous
// result is still untaken when the next one is ready.
// Reset: no clearing pass. A fill flag and the write pointer mark which entries
// of the sample line have been written; unwritten entries read as zero.
module two_tap_delay_pitch_shifter
	import tdps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	tdps_in_if.sink           sample_in,
	tdps_out_if.source        sample_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// ---------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------
	logic [INC_W-1:0]     phase_inc_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= '0;
		end else if (cfg_wr && reg_idx == REG_PHASE_INC) begin
			phase_inc_q <= pwdata[INC_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_PHASE_INC) ? APB_DW'(phase_inc_q) : '0;

	// ---------------------------------------------------------------
	// sequencer and line state
	// ---------------------------------------------------------------
	logic [STEP_W-1:0]  step_q;
	logic [LINE_AW-1:0] wi_q;
	logic               full_q;      // every entry written at least once
	logic [DELAY_W-1:0] tap_delay_q;
	logic               out_vld_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;

	logic in_xfer;
	logic done;
	logic signed [SAMPLE_W-1:0] left_res;
	logic signed [SAMPLE_W-1:0] right_res;

	assign sample_in.ready = (step_q == ST_IDLE);
	assign in_xfer = sample_in.valid & sample_in.ready;
	// last step waits for a free output register
	assign done = (step_q == ST_DONE) & (~out_vld_q | sample_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			wi_q        <= '0;
			full_q      <= 1'b0;
			tap_delay_q <= '0;
		end else begin
			case (step_q)
				ST_IDLE: begin
					if (in_xfer) begin
						step_q <= ST_RD_A0;
					end
				end
				ST_DONE: begin
					if (done) begin
						step_q      <= ST_IDLE;
						wi_q        <= wi_q + 1'b1;
						full_q      <= full_q | (wi_q == LINE_LAST);
						// wrap modulo the line length is the natural overflow
						tap_delay_q <= tap_delay_q
							+ {{(DELAY_W-INC_W){phase_inc_q[INC_W-1]}}, phase_inc_q};
					end
				end
				default: begin
					step_q <= step_q + 1'b1;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// tap positions: the far tap sits half a line further back, so its
	// read and window indices are offset by half the line, same fractions
	// ---------------------------------------------------------------
	logic [DELAY_W-1:0] rd_pos;
	logic [LINE_AW-1:0] ia0;
	logic [FRAC_W-1:0]  frac;
	logic [LINE_AW-1:0] wa0;
	logic [FRAC_W-1:0]  wfrac;
	logic [LINE_AW-1:0] s_raddr;
	logic [LINE_AW-1:0] h_raddr;

	assign rd_pos = {wi_q, {FRAC_W{1'b0}}} - tap_delay_q;
	assign ia0    = rd_pos[DELAY_W-1:FRAC_W];
	assign frac   = rd_pos[FRAC_W-1:0];
	assign wa0    = tap_delay_q[DELAY_W-1:FRAC_W];
	assign wfrac  = tap_delay_q[FRAC_W-1:0];

	always_comb begin
		case (step_q)
			ST_RD_B0: begin
				s_raddr = ia0 + 1'b1;
				h_raddr = wa0 + 1'b1;
			end
			ST_RD_A1: begin
				s_raddr = ia0 + LINE_HALF;
				h_raddr = wa0 + LINE_HALF;
			end
			ST_RD_B1: begin
				s_raddr = ia0 + LINE_HALF + 1'b1;
				h_raddr = wa0 + LINE_HALF + 1'b1;
			end
			default: begin
				s_raddr = ia0;
				h_raddr = wa0;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// sample line (write on input transfer, one registered read)
	// ---------------------------------------------------------------
	logic [2*SAMPLE_W-1:0] smem [LINE_LEN];
	logic [2*SAMPLE_W-1:0] smem_q;
	logic                  smem_ok_q;
	logic [WIN_W-1:0]      hann_q;
	logic signed [SAMPLE_W-1:0] left_rd;
	logic signed [SAMPLE_W-1:0] right_rd;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			smem[wi_q] <= {sample_in.left_in, sample_in.right_in};
		end
		smem_q    <= smem[s_raddr];
		smem_ok_q <= full_q | (s_raddr <= wi_q);
		hann_q    <= HANN_ROM[h_raddr];
	end

	assign left_rd  = smem_ok_q ? $signed(smem_q[2*SAMPLE_W-1:SAMPLE_W]) : '0;
	assign right_rd = smem_ok_q ? $signed(smem_q[SAMPLE_W-1:0]) : '0;

	// ---------------------------------------------------------------
	// datapath strobes; the data of a read appears in the step after it
	// ---------------------------------------------------------------
	tdps_ctl_t ctl;

	always_comb begin
		ctl.load_a   = (step_q == ST_RD_B0) | (step_q == ST_RD_B1);
		ctl.lerp_mul = (step_q == ST_RD_A1) | (step_q == ST_MUL1);
		ctl.lerp_fin = (step_q == ST_RD_B1) | (step_q == ST_FIN1);
		ctl.tap_mul  = (step_q == ST_MUL1) | (step_q == ST_TAP1);
		ctl.acc_init = (step_q == ST_FIN1);
	end

	// ---------------------------------------------------------------
	// window lerp, shared by both channels
	// ---------------------------------------------------------------
	localparam int WP_W = 2 * (WIN_W + 1);

	logic [WIN_W-1:0]       ha_q;
	logic signed [WP_W-1:0] wprod_q;
	logic [WIN_W-1:0]       w_q;
	logic signed [WIN_W:0]  wdiff;
	logic signed [WP_W-1:0] wprod_d;
	logic signed [WP_W-1:0] wsum;

	assign wdiff   = $signed({1'b0, hann_q}) - $signed({1'b0, ha_q});
	assign wprod_d = wdiff * $signed({1'b0, wfrac});
	assign wsum    = $signed({2'b00, ha_q, {FRAC_W{1'b0}}}) + wprod_q
		+ $signed(WP_W'(32768));

	always_ff @(posedge clk) begin
		if (ctl.load_a) begin
			ha_q <= hann_q;
		end
		if (ctl.lerp_mul) begin
			wprod_q <= wprod_d;
		end
		if (ctl.lerp_fin) begin
			w_q <= wsum[FRAC_W+WIN_W-1:FRAC_W];  // at most 32768
		end
	end

	// ---------------------------------------------------------------
	// channel lanes
	// ---------------------------------------------------------------
	tdps_lane u_lane_l (
		.clk    (clk),
		.ctl    (ctl),
		.din    (left_rd),
		.frac   (frac),
		.weight (w_q),
		.dout   (left_res)
	);

	tdps_lane u_lane_r (
		.clk    (clk),
		.ctl    (ctl),
		.din    (right_rd),
		.frac   (frac),
		.weight (w_q),
		.dout   (right_res)
	);

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done) begin
			out_vld_q <= 1'b1;
		end else if (sample_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			left_q  <= left_res;
			right_q <= right_res;
		end
	end

	assign sample_out.valid     = out_vld_q;
	assign sample_out.left_out  = left_q;
	assign sample_out.right_out = right_q;

endmodule

// ===== rtl/tdps_lane.sv =====
// One channel datapath: sample lerp, window weighting, tap accumulate and saturation.
module tdps_lane
	import tdps_pkg::*;
(
	input  logic                       clk,
	input  tdps_ctl_t                  ctl,
	input  logic signed [SAMPLE_W-1:0] din,
	input  logic [FRAC_W-1:0]          frac,
	input  logic [WIN_W-1:0]           weight,
	output logic signed [SAMPLE_W-1:0] dout
);

	localparam int LP_W = SAMPLE_W + 1 + FRAC_W + 1;  // lerp product
	localparam int TP_W = SAMPLE_W + WIN_W + 1;       // tap product
	localparam int TAP_W = SAMPLE_W + 1;

	localparam logic signed [SAMPLE_W+1:0] SAT_MAX = 26'sd8388607;
	localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -26'sd8388608;

	logic signed [SAMPLE_W-1:0] a_q;
	logic signed [LP_W-1:0]     prod_q;
	logic signed [SAMPLE_W-1:0] v_q;
	logic signed [TP_W-1:0]     tprod_q;
	logic signed [TAP_W-1:0]    acc_q;

	logic signed [SAMPLE_W:0]   diff;
	logic signed [FRAC_W:0]     frac_s;
	logic signed [LP_W-1:0]     prod_d;
	logic signed [LP_W-1:0]     lerp_sum;
	logic signed [WIN_W:0]      weight_s;
	logic signed [TP_W-1:0]     tprod_d;
	logic signed [TP_W-1:0]     tap_rnd;
	logic signed [TAP_W-1:0]    tap;
	logic signed [SAMPLE_W+1:0] sum;

	// a*(1-f) + b*f  ==  a + (b-a)*f
	assign diff     = $signed({din[SAMPLE_W-1], din}) - $signed({a_q[SAMPLE_W-1], a_q});
	assign frac_s   = $signed({1'b0, frac});
	assign prod_d   = diff * frac_s;
	assign lerp_sum = $signed({{2{a_q[SAMPLE_W-1]}}, a_q, {FRAC_W{1'b0}}}) + prod_q
		+ $signed(LP_W'(32768));

	assign weight_s = $signed({1'b0, weight});
	assign tprod_d  = v_q * weight_s;
	assign tap_rnd  = tprod_q + $signed(TP_W'(16384));
	assign tap      = tap_rnd[TP_W-2:15];

	always_ff @(posedge clk) begin
		if (ctl.load_a) begin
			a_q <= din;
		end
		if (ctl.lerp_mul) begin
			prod_q <= prod_d;
		end
		if (ctl.lerp_fin) begin
			v_q <= lerp_sum[FRAC_W+SAMPLE_W-1:FRAC_W];
		end
		if (ctl.tap_mul) begin
			tprod_q <= tprod_d;
		end
		if (ctl.acc_init) begin
			acc_q <= tap;
		end
	end

	assign sum = $signed({acc_q[TAP_W-1], acc_q}) + $signed({tap[TAP_W-1], tap});

	always_comb begin
		if (sum > SAT_MAX) begin
			dout = SAT_MAX[SAMPLE_W-1:0];
		end else if (sum < SAT_MIN) begin
			dout = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			dout = sum[SAMPLE_W-1:0];
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the two-tap pitch shifter: directed and random stereo traffic.
module tb_top
	import tdps_pkg::*;
();

	// ---------------------------------------------------------------- constants
	localparam int     WATCHDOG_LIMIT = 3000;  // cycles with no transfer at all
	localparam int     HOLD_CYCLES    = 300;   // long output back-pressure
	localparam int     HOLD_AFTER     = 300;   // pairs out before the long hold
	localparam int     PAIRS_PER_SET  = 115;   // random pairs per increment setting
	localparam int     SETTING_COUNT  = 10;
	localparam int     LOG_LIMIT      = 25;

	localparam logic [APB_AW-1:0] ADDR_PHASE_INC = APB_AW'(4 * REG_PHASE_INC);
	localparam logic [APB_AW-1:0] ADDR_SPARE     = APB_AW'(4);  // no register here

	localparam longint SPAN = longint'(LINE_LEN) << FRAC_W;     // line length in Q16
	localparam logic [DELAY_W-1:0] HALF_SPAN = DELAY_W'(SPAN / 2);
	localparam longint unsigned PI_SCALED = 64'd3373259426;     // pi in Q30
	localparam longint unsigned UNIT_Q30  = 64'd1 << 30;

	localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 24'sh800000;
	localparam logic [INC_W-1:0] INC_HIGH = INC_W'(65536);      // top of legal range
	localparam logic [INC_W-1:0] INC_LOW  = INC_W'(-262144);    // bottom, also 19-bit min
	localparam logic [INC_W-1:0] INC_WILD = INC_W'(262143);     // above range, 19-bit max

	typedef struct {
		logic signed [SAMPLE_W-1:0] l;
		logic signed [SAMPLE_W-1:0] r;
	} stereo_t;

	// ---------------------------------------------------------------- DUT hookup
	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	tdps_in_if  in_ch();
	tdps_out_if out_ch();

	two_tap_delay_pitch_shifter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (in_ch),
		.sample_out (out_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// 4 ns period
	always #2 clk = ~clk;

	// ---------------------------------------------------------------- bench state
	stereo_t pending_pairs[$];    // waiting for the driver
	stereo_t expected_pairs[$];   // predicted outputs, oldest first

	int  pairs_queued;
	int  pairs_checked;
	int  err_count;
	int  sat_hits;
	int  settings_seen;
	int  long_holds;
	int  stall_cycles;
	int  idle_cycles;
	bit  in_took;                 // input transfer at the last rising edge
	bit  out_took;                // output transfer at the last rising edge

	// Shadow of the shifter: line contents, window, pointers, increment.
	logic signed [SAMPLE_W-1:0] line_l [LINE_LEN];
	logic signed [SAMPLE_W-1:0] line_r [LINE_LEN];
	logic [WIN_W-1:0]           win [LINE_LEN];
	logic [LINE_AW-1:0]         wr_ptr;
	logic [DELAY_W-1:0]         tap_pos;
	logic [INC_W-1:0]           inc_shadow;

	// ---------------------------------------------------------------- prediction
	// sin^2(pi*i/N) in Q15; the sine is a Q30 Taylor series out to x^11,
	// evaluated Horner style from the highest term down.
	function automatic logic [WIN_W-1:0] window_weight(int unsigned idx);
		int unsigned     divs [5] = '{110, 72, 42, 20, 6};
		longint unsigned k;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned h;
		k  = (idx <= LINE_LEN / 2) ? longint'(idx) : longint'(LINE_LEN - idx);
		x  = (k * PI_SCALED) / LINE_LEN;
		x2 = (x * x) >> 30;
		t  = UNIT_Q30;
		for (int j = 0; j < 5; j++) begin
			t = UNIT_Q30 - ((x2 * t) >> 30) / divs[j];
		end
		s = (x * t) >> 30;
		h = (((s * s) >> 30) + 64'd16384) >> 15;
		if (h > 64'd32768) begin
			h = 64'd32768;
		end
		return h[WIN_W-1:0];
	endfunction

	// shift right with round half up (floor of x/2^s + 1/2)
	function automatic longint round_shift(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clamp_pcm(longint v);
		if (v > longint'(PCM_MAX)) begin
			sat_hits++;
			return PCM_MAX;
		end
		if (v < longint'(PCM_MIN)) begin
			sat_hits++;
			return PCM_MIN;
		end
		return SAMPLE_W'(v);
	endfunction

	task automatic reset_shadow();
		for (int i = 0; i < LINE_LEN; i++) begin
			line_l[i] = '0;
			line_r[i] = '0;
			win[i]    = window_weight(i);
		end
		wr_ptr     = '0;
		tap_pos    = '0;
		inc_shadow = '0;
	endtask

	// One tap: read position wraps mod 2^27 which equals floor-wrap on the line;
	// the window is indexed by the tap's own delay and uses its fraction.
	task automatic add_tap(input logic [DELAY_W-1:0] dly, inout longint acc_l,
			inout longint acc_r);
		logic [DELAY_W-1:0] rpos;
		logic [LINE_AW-1:0] ia;
		logic [LINE_AW-1:0] ib;
		logic [LINE_AW-1:0] wa;
		logic [LINE_AW-1:0] wb;
		longint             f;
		longint             wf;
		longint             w;
		longint             sl;
		longint             sr;
		rpos = {wr_ptr, FRAC_W'(0)} - dly;
		ia   = rpos[DELAY_W-1:FRAC_W];
		ib   = ia + 1'b1;
		f    = longint'(rpos[FRAC_W-1:0]);
		wa   = dly[DELAY_W-1:FRAC_W];
		wb   = wa + 1'b1;
		wf   = longint'(dly[FRAC_W-1:0]);
		w    = round_shift(longint'(win[wa]) * (65536 - wf) + longint'(win[wb]) * wf, 16);
		sl   = round_shift(longint'(line_l[ia]) * (65536 - f) + longint'(line_l[ib]) * f, 16);
		sr   = round_shift(longint'(line_r[ia]) * (65536 - f) + longint'(line_r[ib]) * f, 16);
		acc_l += round_shift(sl * w, 15);
		acc_r += round_shift(sr * w, 15);
	endtask

	task automatic predict_shift(input stereo_t x, output stereo_t y);
		longint acc_l;
		longint acc_r;
		longint d;
		acc_l = 0;
		acc_r = 0;
		line_l[wr_ptr] = x.l;
		line_r[wr_ptr] = x.r;
		add_tap(tap_pos, acc_l, acc_r);
		add_tap(tap_pos + HALF_SPAN, acc_l, acc_r);
		y.l = clamp_pcm(acc_l);
		y.r = clamp_pcm(acc_r);
		// advance delay by the signed increment, one wrap at most
		d = longint'(tap_pos) + longint'($signed(inc_shadow));
		if (d >= SPAN) begin
			d -= SPAN;
		end
		if (d < 0) begin
			d += SPAN;
		end
		tap_pos = DELAY_W'(d);
		wr_ptr  = wr_ptr + 1'b1;
	endtask

	// ---------------------------------------------------------------- reporting
	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= LOG_LIMIT) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endtask

	// ---------------------------------------------------------------- randomness
	// Mostly back-to-back, some short gaps, a few long ones. In burst mode none.
	function automatic int pick_gap(bit burst);
		int r;
		if (burst) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// full-range noise most of the time, plus extremes and near-zero values
	function automatic logic signed [SAMPLE_W-1:0] draw_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				case ($urandom_range(0, 3))
					0:       return PCM_MAX;
					1:       return PCM_MIN;
					2:       return '0;
					default: return '1;
				endcase
			end
			1, 2: begin
				return SAMPLE_W'(int'($urandom_range(0, 510)) - 255);
			end
			default: begin
				return SAMPLE_W'($urandom());
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- monitor
	// Samples at the rising edge: input transfers feed the predictor, output
	// transfers are checked against the oldest prediction.
	stereo_t seen_in;
	stereo_t seen_out;
	stereo_t want;

	always @(posedge clk) begin
		in_took  = 1'b0;
		out_took = 1'b0;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == ADDR_PHASE_INC) begin
				inc_shadow = pwdata[INC_W-1:0];
			end
			if (in_ch.valid && !in_ch.ready) begin
				stall_cycles++;
			end
			if (in_ch.valid && in_ch.ready) begin
				in_took   = 1'b1;
				seen_in.l = in_ch.left_in;
				seen_in.r = in_ch.right_in;
				predict_shift(seen_in, want);
				expected_pairs.push_back(want);
			end
			if (out_ch.valid && out_ch.ready) begin
				out_took   = 1'b1;
				seen_out.l = out_ch.left_out;
				seen_out.r = out_ch.right_out;
				if (expected_pairs.size() == 0) begin
					flag_error($sformatf("output pair (%0d, %0d) with nothing pending",
						seen_out.l, seen_out.r));
				end else begin
					want = expected_pairs.pop_front();
					if (seen_out.l !== want.l) begin
						flag_error($sformatf("pair %0d left_out: got %0d, want %0d",
							pairs_checked, seen_out.l, want.l));
					end
					if (seen_out.r !== want.r) begin
						flag_error($sformatf("pair %0d right_out: got %0d, want %0d",
							pairs_checked, seen_out.r, want.r));
					end
					pairs_checked++;
				end
			end
		end
	end

	// Watchdog: any transfer, either stream or the register port, counts as progress.
	always @(posedge clk) begin
		if (in_took || out_took || psel || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer", WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------- driver
	// Inputs change on the falling edge. A pair stays offered until taken;
	// after each transfer comes a random gap, drawn when the pair is offered.
	int      src_gap;
	bit      src_burst;
	stereo_t next_pair;

	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0) begin
				src_burst = !src_burst;
			end
			if (!in_ch.valid || in_took) begin
				if (src_gap > 0) begin
					src_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					next_pair = pending_pairs.pop_front();
					in_ch.valid    <= 1'b1;
					in_ch.left_in  <= next_pair.l;
					in_ch.right_in <= next_pair.r;
					src_gap = pick_gap(src_burst);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sink
	// Random ready with its own gaps; once, a long hold-off lets the shifter
	// back up so that its input stalls while the driver keeps offering.
	int snk_gap;
	int hold_left;
	bit snk_burst;
	bit hold_done;

	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 149) == 0) begin
				snk_burst = !snk_burst;
			end
			if (!hold_done && pairs_checked >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				long_holds++;
			end
			if (out_took) begin
				snk_gap = pick_gap(snk_burst);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- register port
	task automatic apb_write(input logic [APB_AW-1:0] a, input logic [APB_DW-1:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic [APB_AW-1:0] a, output logic [APB_DW-1:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ---------------------------------------------------------------- sequencing
	// Wait until every prediction is checked, then let the pipe run idle before going on.
	task automatic settle();
		while (pairs_checked < pairs_queued) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic queue_pair(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		stereo_t p;
		p.l = l;
		p.r = r;
		pending_pairs.push_back(p);
		pairs_queued++;
	endtask

	// Program the increment while idle, read it back, then queue traffic.
	task automatic run_setting(input logic [INC_W-1:0] inc, input int n, input bit edges);
		logic [APB_DW-1:0] rd;
		settle();
		apb_write(ADDR_PHASE_INC, APB_DW'($signed(inc)));
		apb_read(ADDR_PHASE_INC, rd);
		if (rd[INC_W-1:0] !== inc) begin
			flag_error($sformatf("phase_increment readback %h, wrote %h",
				rd[INC_W-1:0], inc));
		end
		settings_seen++;
		@(posedge clk);
		if (edges) begin
			// field extremes and alternating bit patterns
			queue_pair(PCM_MAX, PCM_MIN);
			queue_pair(PCM_MIN, PCM_MAX);
			queue_pair(PCM_MAX, PCM_MAX);
			queue_pair(PCM_MIN, PCM_MIN);
			queue_pair('0, '0);
			queue_pair('1, '1);
			queue_pair(24'sh555555, 24'shAAAAAA);
			queue_pair(24'shAAAAAA, 24'sh555555);
			queue_pair(24'sh000001, '1);
			queue_pair(PCM_MAX, PCM_MAX);
			queue_pair(PCM_MAX, PCM_MAX);
			queue_pair(PCM_MIN, PCM_MIN);
		end else begin
			for (int i = 0; i < n; i++) begin
				queue_pair(draw_sample(), draw_sample());
			end
		end
	endtask

	logic [INC_W-1:0]  inc_plan [SETTING_COUNT];
	logic [APB_DW-1:0] spare_rd;

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_ch.valid    = 1'b0;
		in_ch.left_in  = '0;
		in_ch.right_in = '0;
		out_ch.ready   = 1'b0;
		reset_shadow();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A write to an address with no register must change nothing.
		apb_write(ADDR_SPARE, '1);
		apb_read(ADDR_PHASE_INC, spare_rd);
		if (spare_rd[INC_W-1:0] !== '0) begin
			flag_error($sformatf("spare write disturbed phase_increment: %h",
				spare_rd[INC_W-1:0]));
		end

		// Directed: extremes with a still delay, then with the fastest backward
		// sweep so the delay goes negative and wraps right away.
		run_setting('0, 0, 1'b1);
		run_setting(INC_LOW, 0, 1'b1);

		// Random: both range ends, an out-of-range value, tiny and fractional
		// steps, and a few drawn settings (one of them any 19-bit value).
		inc_plan[0] = INC_HIGH;
		inc_plan[1] = INC_LOW;
		inc_plan[2] = INC_WILD;
		inc_plan[3] = '0;
		inc_plan[4] = '1;
		inc_plan[5] = INC_W'(1);
		inc_plan[6] = INC_W'(65535);
		inc_plan[7] = INC_W'($urandom_range(0, 327680) - 262144);
		inc_plan[8] = INC_W'($urandom_range(0, 327680) - 262144);
		inc_plan[9] = INC_W'($urandom());
		for (int s = 0; s < SETTING_COUNT; s++) begin
			run_setting(inc_plan[s], PAIRS_PER_SET, 1'b0);
		end

		settle();
		repeat (30) @(negedge clk);
		if (expected_pairs.size() != 0) begin
			flag_error($sformatf("%0d predicted pairs never came out",
				expected_pairs.size()));
		end

		$display("covered %0d stereo pairs over %0d increment settings, %0d clipped samples",
			pairs_checked, settings_seen, sat_hits);
		$display("%0d long output hold-off(s), input stalled for %0d cycles, %0d errors",
			long_holds, stall_cycles, err_count);
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tdps_pkg.sv
rtl/tdps_in_if.sv
rtl/tdps_out_if.sv
rtl/tdps_lane.sv
rtl/two_tap_delay_pitch_shifter.sv
bench/tb_top.sv
